/* rtl/cait_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cait_pkg: shared types, constants and functions of the injection timer
// Holds the field widths, register indexes, the reciprocal used for the
// period scaling and the controller to datapath command struct.
// ----------------------------------------------------------------------------
package cait_pkg;

	// Widths of the counters and the configuration registers.
	localparam int CAPTURE_W = 16;
	localparam int TIMER_W   = 16;
	localparam int TOOTH_W   = 6;
	localparam int ANGLE_W   = 9;
	localparam int INJ_W     = 16;
	localparam int TICK_W    = 10;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INJ_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_NS  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [ANGLE_W-1:0] ANGLE_RST    = 9'd53;
	localparam logic [INJ_W-1:0]   INJ_TIME_RST = 16'd3200;
	localparam logic [TICK_W-1:0]  TICK_NS_RST  = 10'd356;

	// Crank geometry.
	localparam logic [ANGLE_W-1:0] FULL_TURN = 9'd360;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 9'd359;
	localparam logic [TOOTH_W-1:0] TOOTH_MAX = 6'd63;

	// Divide by ten of a value below 1024: (x * 205) >> 11 is exact there.
	localparam int DIV10_MUL_W = 8;
	localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 8'd205;
	localparam int DIV10_SH = 11;

	// Tooth period in ns and its exact divide by 10000 through a reciprocal.
	localparam int PERIOD_W  = CAPTURE_W + TICK_W;
	localparam int PERIOD_DIV = 10000;
	localparam int RECIP_SH  = PERIOD_W + 14;
	localparam int RECIP_W   = PERIOD_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(PERIOD_DIV - 1)) / 64'(PERIOD_DIV));
	localparam int PROD_W    = PERIOD_W + RECIP_W;
	localparam int QUOT_W    = PROD_W - RECIP_SH;
	localparam int DIGIT_W   = 4;
	localparam int DELAY_W   = QUOT_W + DIGIT_W;

	localparam logic [63:0] TMR_MAX = (64'd1 << TIMER_W) - 64'd1;

	typedef logic [TIMER_W-1:0]   timer_t;
	typedef logic [CAPTURE_W-1:0] capture_t;
	typedef logic [TOOTH_W-1:0]   tooth_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic commit;
	} cmd_t;

	// Clamp a value to the largest timer count.
	function automatic timer_t sat_timer(input logic [31:0] v);
		if ({32'd0, v} > TMR_MAX) begin
			return {TIMER_W{1'b1}};
		end else begin
			return v[TIMER_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

/* rtl/cait_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cait_if: request and result channels of the injection timer
// Valid/ready channels; a request moves at an edge where both are high.
// ----------------------------------------------------------------------------

// Input channel: one time step of crank and tick events.
interface cait_in_if;
	logic valid;
	logic ready;
	logic tooth_edge;
	logic tdc_edge;
	logic capture_tick;
	logic micro_tick;

	modport source (output valid, output tooth_edge, output tdc_edge,
		output capture_tick, output micro_tick, input ready);
	modport sink (input valid, input tooth_edge, input tdc_edge,
		input capture_tick, input micro_tick, output ready);
endinterface

// Output channel: injector state after one time step.
interface cait_out_if;
	logic       valid;
	logic       ready;
	logic       injector_on;
	logic [5:0] tooth_index;
	logic       timer_running;

	modport source (output valid, output injector_on, output tooth_index,
		output timer_running, input ready);
	modport sink (input valid, input injector_on, input tooth_index,
		input timer_running, output ready);
endinterface
`default_nettype wire

/* rtl/crank_angle_injection_timer_core.sv */
`default_nettype none
// A request with a tooth edge passes the three multiply stages MUL1, MUL2 and
// MUL3 before the update state APPLY; any other request goes to APPLY directly.
// The result is registered on commit, which waits while an older result is untaken;
// a new request is only taken once the request before it has committed.
// Reset: arst_n clears all counters and the injector, and loads the default
// injection angle, injection time and capture tick length.
// ----------------------------------------------------------------------------
// crank_angle_injection_timer_core: crank angle fuel injection scheduler
// Counts crank teeth, measures the tooth period and times the injector delay
// and open time in microsecond ticks.
// ----------------------------------------------------------------------------
module crank_angle_injection_timer_core
	import cait_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	cait_in_if.sink                    in_ch,
	cait_out_if.source                 out_ch
);

	cmd_t cmd;

	// Request sequencer.
	cait_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_tooth  (in_ch.tooth_edge),
		.out_ready (out_ch.ready),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// Counters, timer and delay arithmetic.
	cait_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.tooth_edge    (in_ch.tooth_edge),
		.tdc_edge      (in_ch.tdc_edge),
		.capture_tick  (in_ch.capture_tick),
		.micro_tick    (in_ch.micro_tick),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.injector_on   (out_ch.injector_on),
		.tooth_index   (out_ch.tooth_index),
		.timer_running (out_ch.timer_running)
	);

endmodule
`default_nettype wire

/* rtl/cait_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cait_ctrl: request sequencer of the injection timer
// Steps a request through the multiply chain when it carries a tooth edge
// and commits the state update once the result register is free.
// ----------------------------------------------------------------------------
module cait_ctrl
	import cait_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic in_valid,
	input  wire  logic in_tooth,
	input  wire  logic out_ready,
	output logic       in_ready,
	output logic       out_valid,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL1  = 3'd1;
	localparam logic [2:0] ST_MUL2  = 3'd2;
	localparam logic [2:0] ST_MUL3  = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       apply_go;

	// The update may only land when the previous result has been taken.
	assign in_ready = (state_q == ST_IDLE);
	assign apply_go = (state_q == ST_APPLY) && !(out_valid_q && !out_ready);
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd.load   = in_valid && in_ready;
		cmd.mul1   = (state_q == ST_MUL1);
		cmd.mul2   = (state_q == ST_MUL2);
		cmd.mul3   = (state_q == ST_MUL3);
		cmd.commit = apply_go;
	end

	// Next state: tooth steps take the multiply chain, others go straight on.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_tooth ? ST_MUL1 : ST_APPLY;
				end
			end
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_APPLY;
			ST_APPLY: begin
				if (apply_go) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// State and result flag registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// A committed update is always offered as a result.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not raise the result valid");

	// The last multiply stage always leads to the update.
	a_mul3_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL3) |=> (state_q == ST_APPLY))
		else $error("multiply chain did not reach the update state");

	// A pending result is never overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("update committed over an untaken result");
`endif

endmodule
`default_nettype wire

/* rtl/cait_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cait_dp: datapath of the injection timer
// Holds configuration and timer state, computes the injection delay from
// the tooth period over three multiply stages and applies one time step.
// ----------------------------------------------------------------------------
module cait_dp
	import cait_pkg::*;
(
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	input  wire  cmd_t                  cmd,
	input  wire  logic                  tooth_edge,
	input  wire  logic                  tdc_edge,
	input  wire  logic                  capture_tick,
	input  wire  logic                  micro_tick,
	input  wire  logic                  cfg_we,
	input  wire  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                        injector_on,
	output tooth_t                      tooth_index,
	output logic                        timer_running
);

	// Configuration registers.
	logic [ANGLE_W-1:0] angle_q;
	logic [INJ_W-1:0]   inj_time_q;
	logic [TICK_W-1:0]  tick_ns_q;

	// Timer state.
	capture_t capture_count_q;
	tooth_t   tooth_count_q;
	logic     injector_q;
	logic     timer_active_q;
	timer_t   timer_count_q;
	timer_t   timer_limit_q;

	// Latched request and multiply chain.
	logic                tooth_q;
	logic                tdc_q;
	logic                cap_q;
	logic                micro_q;
	logic [PERIOD_W-1:0] period_s1;
	logic [PROD_W-1:0]   prod_s2;
	timer_t              delay_s3;

	// Target tooth and leftover degrees.
	logic [ANGLE_W-1:0]             angle_clamped;
	logic [ANGLE_W-1:0]             rest;
	logic [ANGLE_W+DIV10_MUL_W-1:0] rest_scaled;
	tooth_t                         target;
	logic [DIGIT_W-1:0]             digit;
	logic [QUOT_W-1:0]              quot;
	logic [DELAY_W-1:0]             delay;

	// Next state.
	capture_t cc_d;
	tooth_t   tc_d;
	logic     inj_d;
	logic     ta_d;
	timer_t   tcnt_d;
	timer_t   tl_d;

	// Degrees left to top dead centre, split into whole teeth and a remainder.
	assign angle_clamped = (angle_q > ANGLE_MAX) ? ANGLE_MAX : angle_q;
	assign rest          = FULL_TURN - angle_clamped;
	assign rest_scaled   = (ANGLE_W+DIV10_MUL_W)'(rest) * (ANGLE_W+DIV10_MUL_W)'(DIV10_MUL);
	assign target        = rest_scaled[DIV10_SH +: TOOTH_W];
	assign digit         = DIGIT_W'(rest - ANGLE_W'(target) * ANGLE_W'(4'd10));

	// Period divided by 10000, then scaled by the leftover degrees.
	assign quot  = prod_s2[RECIP_SH +: QUOT_W];
	assign delay = DELAY_W'(digit) * DELAY_W'(quot);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= ANGLE_RST;
			inj_time_q <= INJ_TIME_RST;
			tick_ns_q  <= TICK_NS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ANGLE:    angle_q    <= cfg_wdata[ANGLE_W-1:0];
				CFG_INJ_TIME: inj_time_q <= cfg_wdata[INJ_W-1:0];
				CFG_TICK_NS:  tick_ns_q  <= cfg_wdata[TICK_W-1:0];
				default:      ;
			endcase
		end
	end

	// Request latch and multiply chain.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tooth_q <= tooth_edge;
			tdc_q   <= tdc_edge;
			cap_q   <= capture_tick;
			micro_q <= micro_tick;
		end
		if (cmd.mul1) begin
			period_s1 <= PERIOD_W'(capture_count_q) * PERIOD_W'(tick_ns_q);
		end
		if (cmd.mul2) begin
			prod_s2 <= PROD_W'(period_s1) * PROD_W'(RECIP);
		end
		if (cmd.mul3) begin
			delay_s3 <= sat_timer(32'(delay));
		end
	end

	// One time step: tooth edge, TDC edge, capture tick, microsecond tick.
	always_comb begin
		cc_d   = capture_count_q;
		tc_d   = tooth_count_q;
		inj_d  = injector_q;
		ta_d   = timer_active_q;
		tcnt_d = timer_count_q;
		tl_d   = timer_limit_q;
		if (tooth_q) begin
			if (tc_d != TOOTH_MAX) begin
				tc_d = tc_d + 6'd1;
			end
			cc_d = '0;
			if (tc_d == target) begin
				tl_d   = delay_s3;
				tcnt_d = '0;
				ta_d   = 1'b1;
			end
		end
		if (tdc_q) begin
			tc_d = '0;
		end
		if (cap_q) begin
			cc_d = cc_d + CAPTURE_W'(1);
		end
		if (micro_q && ta_d) begin
			if (tcnt_d >= tl_d) begin
				tcnt_d = '0;
				if (!inj_d) begin
					inj_d = 1'b1;
					tl_d  = sat_timer(32'(inj_time_q));
				end else begin
					inj_d = 1'b0;
					ta_d  = 1'b0;
				end
			end else begin
				tcnt_d = tcnt_d + TIMER_W'(1);
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_count_q <= '0;
			tooth_count_q   <= '0;
			injector_q      <= 1'b0;
			timer_active_q  <= 1'b0;
			timer_count_q   <= '0;
			timer_limit_q   <= '0;
		end else if (cmd.commit) begin
			capture_count_q <= cc_d;
			tooth_count_q   <= tc_d;
			injector_q      <= inj_d;
			timer_active_q  <= ta_d;
			timer_count_q   <= tcnt_d;
			timer_limit_q   <= tl_d;
		end
	end

	assign injector_on   = injector_q;
	assign tooth_index   = tooth_count_q;
	assign timer_running = timer_active_q;

`ifndef ASSERT_OFF
	// The injector is only open while its timer runs.
	a_inj_timer: assert property (@(posedge clk) disable iff (!arst_n)
		injector_q |-> timer_active_q)
		else $error("injector open with the timer stopped");

	// The timer count never passes its limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		timer_count_q <= timer_limit_q)
		else $error("timer count above its limit");

	// Visible state only moves on a commit.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> ($stable(tooth_count_q) && $stable(injector_q)))
		else $error("state changed without a commit");
`endif

endmodule
`default_nettype wire
